FILE: hw/rtl/iira_pkg.sv
// ----------------------------------------------------------------------------
// iira_pkg
// Shared constants, codes and types for the indexed insert/remove array unit.
// ----------------------------------------------------------------------------
package iira_pkg;

  localparam int DEPTH = 256;
  localparam int WIDTH = 32;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // fixed field widths of the channels
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // signed compare width covering both position and count
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OPCODE_W-1:0] OP_READ      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REM_LAST  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INSERT    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REMOVE_AT = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic signed [POS_W-1:0] position;
    logic [VALUE_W-1:0]      value_in;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value_out;
    status_t            status;
    logic [COUNT_W-1:0] count_out;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WIDTH-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/iira_if.sv
// ----------------------------------------------------------------------------
// iira_if
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface iira_req_if;
  import iira_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPCODE_W-1:0]     opcode;
  logic signed [POS_W-1:0] position;
  logic [VALUE_W-1:0]      value_in;

  modport source (output valid, output opcode, output position, output value_in,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value_in,
                  output ready);
endinterface

interface iira_rsp_if;
  import iira_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] count_out;

  modport source (output valid, output value_out, output status, output count_out,
                  input ready);
  modport sink   (input valid, input value_out, input status, input count_out,
                  output ready);
endinterface

FILE: hw/rtl/iira_ram.sv
// ----------------------------------------------------------------------------
// iira_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module iira_ram #(
  parameter int DW = 32,
  parameter int DD = 256
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [$clog2(DD)-1:0] waddr,
  input  logic [DW-1:0]         wdata,
  input  logic                  re,
  input  logic [$clog2(DD)-1:0] raddr,
  output logic [DW-1:0]         rdata
);

  logic [DW-1:0] mem [DD];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/iira_ctrl.sv
// ----------------------------------------------------------------------------
// iira_ctrl
// Sequencer: index checks, then one memory move per cycle through the shared
// read/write path, holding the count and the result of the current beat.
// ----------------------------------------------------------------------------
module iira_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  iira_pkg::req_t     req,
  output logic               idle,
  output logic               done,
  input  logic               done_take,
  output iira_pkg::rsp_t     rsp,
  output iira_pkg::mem_req_t mem_req,
  input  logic [iira_pkg::WIDTH-1:0] rdata
);
  import iira_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_SHIFT = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [OPCODE_W-1:0]     op;
  logic signed [POS_W-1:0] pos;
  logic [WIDTH-1:0]        val;
  logic [WIDTH-1:0]        res;
  status_t                 status;
  logic [ADDR_W-1:0]       src;
  logic [ADDR_W-1:0]       last_src;
  logic [ADDR_W-1:0]       pend_addr;
  logic [ADDR_W-1:0]       put_addr;
  logic                    step_up;
  logic                    cap_first;
  logic                    first;
  logic                    pend_wr;
  logic                    cap_pend;
  logic                    do_put;

  logic signed [CMP_W-1:0] pos_x;
  logic signed [CMP_W-1:0] cnt_x;
  logic signed [CMP_W-1:0] rd_idx;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    bad_read;
  logic                    bad_ins;
  logic                    bad_rem;
  logic                    full;

  always_comb begin
    pos_x    = CMP_W'(pos);
    cnt_x    = CMP_W'(cnt);
    cnt_m1   = cnt - 1'b1;
    rd_idx   = (pos_x < 0) ? (pos_x + cnt_x) : pos_x;
    bad_read = (pos_x < -cnt_x) || (pos_x >= cnt_x);
    bad_ins  = (pos_x < 0) || (pos_x > cnt_x);
    bad_rem  = (pos_x < 0) || (pos_x >= cnt_x);
    full     = (cnt >= CNT_W'(DEPTH));
  end

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = rdata;
    mem_req.raddr = src;
    mem_req.waddr = pend_addr;
    case (state)
      S_SHIFT: begin
        mem_req.re = 1'b1;
        mem_req.we = pend_wr;
      end
      S_DRAIN: begin
        mem_req.we = pend_wr;
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = put_addr;
        mem_req.wdata = val;
      end
      default: begin
      end
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    rsp.value_out = VALUE_W'(res);
    rsp.status    = status;
    rsp.count_out = COUNT_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      pend_wr  <= 1'b0;
      cap_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= req.opcode;
            pos   <= req.position;
            val   <= WIDTH'(req.value_in);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res      <= '0;
          status   <= ST_OK;
          first    <= 1'b1;
          pend_wr  <= 1'b0;
          cap_pend <= 1'b0;
          do_put   <= 1'b0;
          case (op)
            OP_READ: begin
              if (bad_read) begin
                status <= ST_RANGE;
                state  <= S_DONE;
              end else begin
                src       <= ADDR_W'(rd_idx);
                last_src  <= ADDR_W'(rd_idx);
                step_up   <= 1'b1;
                cap_first <= 1'b1;
                state     <= S_SHIFT;
              end
            end
            OP_APPEND: begin
              if (full) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                put_addr <= ADDR_W'(cnt);
                cnt      <= cnt + 1'b1;
                state    <= S_PUT;
              end
            end
            OP_REM_LAST: begin
              if (cnt == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else begin
                src       <= ADDR_W'(cnt_m1);
                last_src  <= ADDR_W'(cnt_m1);
                step_up   <= 1'b1;
                cap_first <= 1'b1;
                cnt       <= cnt_m1;
                state     <= S_SHIFT;
              end
            end
            OP_INSERT: begin
              if (bad_ins) begin
                status <= ST_RANGE;
                state  <= S_DONE;
              end else if (full) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                put_addr <= ADDR_W'(pos_x);
                cnt      <= cnt + 1'b1;
                if (pos_x == cnt_x) begin
                  state <= S_PUT;
                end else begin
                  // move top element down to pos one slot up, then drop value in
                  src       <= ADDR_W'(cnt_m1);
                  last_src  <= ADDR_W'(pos_x);
                  step_up   <= 1'b0;
                  cap_first <= 1'b0;
                  do_put    <= 1'b1;
                  state     <= S_SHIFT;
                end
              end
            end
            OP_REMOVE_AT: begin
              if (bad_rem) begin
                status <= ST_RANGE;
                state  <= S_DONE;
              end else begin
                src       <= ADDR_W'(pos_x);
                last_src  <= ADDR_W'(cnt_m1);
                step_up   <= 1'b1;
                cap_first <= 1'b1;
                cnt       <= cnt_m1;
                state     <= S_SHIFT;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SHIFT: begin
          // read data of the previous cycle is either the result or a move
          if (cap_pend) begin
            res <= rdata;
          end
          cap_pend  <= first && cap_first;
          pend_wr   <= !(first && cap_first);
          pend_addr <= step_up ? (src - 1'b1) : (src + 1'b1);
          first     <= 1'b0;
          if (src == last_src) begin
            state <= S_DRAIN;
          end else begin
            src <= step_up ? (src + 1'b1) : (src - 1'b1);
          end
        end
        S_DRAIN: begin
          if (cap_pend) begin
            res <= rdata;
          end
          pend_wr  <= 1'b0;
          cap_pend <= 1'b0;
          state    <= do_put ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (done_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_req.we)
    else $error("memory write while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  a_move_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend_wr) |-> (pend_addr != src))
    else $error("shift writes the slot it reads");

  a_take_to_idle: assert property (@(posedge clk) disable iff (rst)
    (done && done_take) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

FILE: hw/rtl/indexed_insert_remove_array_unit.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_unit
// Fixed-capacity ordered array: read, append, remove last, insert and remove
// at an index, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  ----------+-----+-----------------------------------------
//  request   | in  | opcode[2:0], position[9:0] signed, value_in[31:0]
//  response  | out | value_out[31:0], status[1:0], count_out[8:0]
//
// one request at a time: ready only while the sequencer is idle
// read / remove last go through check, shift and drain; append and insert at the end
// through check and put; an error or an unused opcode from check straight to done;
// insert and remove at an index shift the elements moved, one memory move per cycle
// on the single read and write port of the element RAM
// rst clears the count; the element RAM is not cleared and needs no sweep
// a response waits in the output register; the next request is taken while it
// stalls, and the sequencer holds its result until the register frees up
module indexed_insert_remove_array_unit (
  input  logic clk,
  input  logic rst,
  iira_req_if.sink   request,
  iira_rsp_if.source response
);
  import iira_pkg::*;

  req_t              req;
  rsp_t              rsp;
  mem_req_t          mem_req;
  logic [WIDTH-1:0]  rdata;
  logic              idle;
  logic              done;
  logic              done_take;
  logic              accept;
  logic              out_valid;
  rsp_t              out_rsp;

  assign request.ready = idle;
  assign accept        = request.valid && idle;

  always_comb begin
    req.opcode   = request.opcode;
    req.position = request.position;
    req.value_in = request.value_in;
  end

  iira_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .idle      (idle),
    .done      (done),
    .done_take (done_take),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  iira_ram #(
    .DW (WIDTH),
    .DD (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // output register frees when empty or being taken this cycle
  assign done_take = done && (!out_valid || response.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_take) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_take) begin
      out_rsp <= rsp;
    end
  end

  assign response.valid     = out_valid;
  assign response.value_out = out_rsp.value_out;
  assign response.status    = out_rsp.status;
  assign response.count_out = out_rsp.count_out;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed insert/remove array unit. A scoreboard
// class keeps its own copy of the array and predicts every response beat.
// Stimulus is a short directed sweep, then random traffic that grows the
// array to chosen levels (full included) and churns around them, under
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import iira_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = 3'd5;

  class array_scoreboard;
    logic [WIDTH-1:0] elems [DEPTH];
    int n;
    rsp_t expected_q [$];
    int errors;
    int beats;

    function new();
      n = 0;
      errors = 0;
      beats = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("tb: mismatch at response %0d: %s", beats, msg);
      errors++;
    endtask

    // apply one accepted request to the array copy and queue its response
    function void note_request(req_t r);
      rsp_t e;
      int p;
      int i;
      e.value_out = '0;
      e.status = ST_OK;
      p = $signed(r.position);
      case (r.opcode)
        OP_READ: begin
          if (p < -n || p >= n) e.status = ST_RANGE;
          else e.value_out = elems[(p < 0) ? p + n : p];
        end
        OP_APPEND: begin
          if (n >= DEPTH) e.status = ST_FULL;
          else begin
            elems[n] = r.value_in;
            n++;
          end
        end
        OP_REM_LAST: begin
          if (n == 0) e.status = ST_EMPTY;
          else begin
            n--;
            e.value_out = elems[n];
          end
        end
        OP_INSERT: begin
          // index check comes before the full check
          if (p < 0 || p > n) e.status = ST_RANGE;
          else if (n >= DEPTH) e.status = ST_FULL;
          else begin
            for (i = n; i > p; i--) elems[i] = elems[i-1];
            elems[p] = r.value_in;
            n++;
          end
        end
        OP_REMOVE_AT: begin
          if (p < 0 || p >= n) e.status = ST_RANGE;
          else begin
            e.value_out = elems[p];
            for (i = p + 1; i < n; i++) elems[i-1] = elems[i];
            n--;
          end
        end
        default: ;
      endcase
      e.count_out = COUNT_W'(n);
      expected_q.push_back(e);
    endfunction

    task check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat value %h status %0d count %0d",
                         got.value_out, int'(got.status), got.count_out));
      end else begin
        e = expected_q.pop_front();
        if (got.value_out !== e.value_out)
          report($sformatf("value_out %h, expected %h", got.value_out, e.value_out));
        if (got.status !== e.status)
          report($sformatf("status %0d, expected %0d", int'(got.status), int'(e.status)));
        if (got.count_out !== e.count_out)
          report($sformatf("count_out %0d, expected %0d", got.count_out, e.count_out));
      end
      beats++;
    endtask
  endclass

  logic clk;
  logic rst;

  iira_req_if req_ch ();
  iira_rsp_if rsp_ch ();

  indexed_insert_remove_array_unit dut (
    .clk(clk),
    .rst(rst),
    .request(req_ch),
    .response(rsp_ch)
  );

  array_scoreboard sb = new();

  int send_idle;
  int recv_idle;
  int hold_request;
  int hold_left;
  int gen_cnt;
  int target;
  int hover_left;
  bit at_target;
  req_t seen_req;
  rsp_t seen_rsp;

  logic [OPCODE_W-1:0] op_list [5] = '{OP_READ, OP_APPEND, OP_REM_LAST, OP_INSERT,
                                       OP_REMOVE_AT};

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen_req.opcode = req_ch.opcode;
        seen_req.position = req_ch.position;
        seen_req.value_in = req_ch.value_in;
        sb.note_request(seen_req);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_rsp.value_out = rsp_ch.value_out;
        seen_rsp.status = status_t'(rsp_ch.status);
        seen_rsp.count_out = rsp_ch.count_out;
        sb.check_response(seen_rsp);
      end
    end
  end

  // response side: random stalls, plus long hold-offs on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // array size after an item, for steering the random traffic
  function automatic int count_after(logic [OPCODE_W-1:0] op, int pos, int cnt);
    case (op)
      OP_APPEND:    return (cnt < DEPTH) ? cnt + 1 : cnt;
      OP_REM_LAST:  return (cnt > 0) ? cnt - 1 : cnt;
      OP_INSERT:    return (pos >= 0 && pos <= cnt && cnt < DEPTH) ? cnt + 1 : cnt;
      OP_REMOVE_AT: return (pos >= 0 && pos < cnt) ? cnt - 1 : cnt;
      default:      return cnt;
    endcase
  endfunction

  // mostly in range, sometimes just outside or anywhere in the field
  function automatic int pick_pos(int lo, int hi);
    int r;
    r = $urandom_range(99);
    if (hi >= lo && r < 85) return lo + int'($urandom_range(hi - lo));
    else if (r < 90) return hi + 1;
    else if (r < 95) return lo - 1;
    else return int'($urandom_range(1023)) - 512;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input int pos,
                           input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.position <= POS_W'(pos);
    req_ch.value_in <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    gen_cnt = count_after(op, pos, gen_cnt);
  endtask

  // drop valid and pause until every response has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_item(output logic [OPCODE_W-1:0] op, output int pos,
                           output logic [VALUE_W-1:0] val);
    int r;
    if (at_target && hover_left == 0) begin
      at_target = 0;
      r = $urandom_range(99);
      if (r < 25) target = DEPTH;
      else if (r < 65) target = $urandom_range(6);
      else target = $urandom_range(120, 20);
    end
    if (!at_target && gen_cnt >= target - 2 && gen_cnt <= target + 2) begin
      at_target = 1;
      hover_left = $urandom_range(40, 15);
    end
    if (at_target) hover_left--;

    r = $urandom_range(99);
    if (r < 4) op = OP_FIRST_UNUSED + 3'($urandom_range(2));
    else if (at_target) op = op_list[$urandom_range(4)];
    else if (gen_cnt < target) op = (r < 70) ? OP_APPEND : (r < 85) ? OP_INSERT : OP_READ;
    else op = (r < 55) ? OP_REM_LAST : (r < 85) ? OP_REMOVE_AT : OP_READ;

    case (op)
      OP_READ:      pos = pick_pos(-gen_cnt, gen_cnt - 1);
      OP_INSERT:    pos = pick_pos(0, gen_cnt);
      OP_REMOVE_AT: pos = pick_pos(0, gen_cnt - 1);
      default:      pos = int'($urandom_range(1023)) - 512;
    endcase

    r = $urandom_range(99);
    if (r < 10) val = '0;
    else if (r < 20) val = '1;
    else val = $urandom;
  endtask

  task automatic run_random(input int items, input bit with_hold);
    logic [OPCODE_W-1:0] op;
    int pos;
    logic [VALUE_W-1:0] val;
    for (int k = 0; k < items; k++) begin
      // long response stall while requests keep coming
      if (with_hold && k == 60) hold_request = 400;
      pick_item(op, pos, val);
      send_item(op, pos, val);
    end
  endtask

  initial begin
    #3_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.position = '0;
    req_ch.value_in = '0;
    hold_request = 0;
    gen_cnt = 0;
    target = DEPTH;
    at_target = 0;
    hover_left = 0;
    send_idle = 34;
    recv_idle = 57;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty array corner cases
    send_item(OP_READ, 0, 32'h1111_1111);
    send_item(OP_READ, -1, 32'h0);
    send_item(OP_REM_LAST, 0, 32'h0);
    send_item(OP_REMOVE_AT, 0, 32'h0);
    send_item(OP_INSERT, 1, 32'h2222_2222);
    send_item(OP_INSERT, -1, 32'h3333_3333);
    // build a small array
    send_item(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 511, 32'h0000_0000);
    send_item(OP_APPEND, -512, 32'hA5A5_5A5A);
    send_item(OP_INSERT, 3, 32'h1234_5678);
    send_item(OP_INSERT, 1, 32'h8000_0001);
    // reads at both ends and just past them
    send_item(OP_READ, -5, 32'h0);
    send_item(OP_READ, 4, 32'h0);
    send_item(OP_READ, -6, 32'h0);
    send_item(OP_READ, 5, 32'h0);
    send_item(OP_READ, 511, 32'hFFFF_FFFF);
    send_item(OP_READ, -512, 32'h0);
    // removals
    send_item(OP_REMOVE_AT, 5, 32'h0);
    send_item(OP_REMOVE_AT, -1, 32'h0);
    send_item(OP_REMOVE_AT, 0, 32'h0);
    send_item(OP_REMOVE_AT, 3, 32'h0);
    send_item(OP_REM_LAST, 0, 32'h0);
    // unused opcodes do nothing
    send_item(OP_FIRST_UNUSED, -512, 32'hFFFF_FFFF);
    send_item(OP_FIRST_UNUSED + 3'd1, 511, 32'h0);
    send_item(OP_FIRST_UNUSED + 3'd2, 0, $urandom);
    drain();

    run_random(270, 1'b1);
    drain();
    send_idle = 57;
    recv_idle = 34;
    run_random(270, 1'b0);
    drain();
    send_idle = 0;
    recv_idle = 0;
    run_random(270, 1'b0);
    drain();

    repeat (300) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
